/* src/plane_tilt_point_rotator_unit_defines.svh */
// ----------------------------------------------------------------------------
// Plane tilt point rotator assertion macros
// Shared concurrent assertion helpers for the rotator RTL.
// ----------------------------------------------------------------------------
`ifndef PLANE_TILT_POINT_ROTATOR_UNIT_DEFINES_SVH
`define PLANE_TILT_POINT_ROTATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define PTR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("property failed");
`define PTR_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define PTR_ASSERT(lbl, clk, rstn, prop)
`define PTR_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

/* src/ptr_pkg.sv */
// ----------------------------------------------------------------------------
// Plane tilt point rotator package
// Widths, codes, types and constants shared by the rotator files.
// ----------------------------------------------------------------------------
package ptr_pkg;

  localparam int COORD_W         = 32;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int COEFF_FRAC_BITS = 30;
  localparam int SQRT_ITERATIONS = 32;
  localparam int COEFF_W         = COEFF_FRAC_BITS + 2;
  localparam int PROD_W          = COORD_W + COEFF_W;
  localparam int SUM_W           = PROD_W + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEFF_W-1:0] coeff_t;
  typedef coeff_t [8:0] coeff_mat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X    = 2'd0,
    REG_NORMAL_Y    = 2'd1,
    REG_NORMAL_Z    = 2'd2,
    REG_ROTATE_MODE = 2'd3
  } ptr_reg_e;

  typedef enum logic [1:0] {
    MODE_IDENTITY = 2'd0,
    MODE_FORWARD  = 2'd1,
    MODE_INVERSE  = 2'd2
  } ptr_mode_e;

  typedef struct packed {
    logic ready;
    logic bad;
  } ptr_setup_st_t;

  localparam coord_t NORMAL_Z_RESET = coord_t'(65536);
  localparam coeff_t COEFF_ONE = coeff_t'(1) << COEFF_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (COEFF_FRAC_BITS - 1);

  function automatic coeff_mat_t identity_mat();
    coeff_mat_t m;
    for (int k = 0; k < 9; k++) begin
      m[k] = (k % 4 == 0) ? COEFF_ONE : '0;
    end
    return m;
  endfunction

  localparam coeff_mat_t COEFF_IDENTITY = identity_mat();

endpackage

/* src/ptr_in_if.sv */
// ----------------------------------------------------------------------------
// Point input channel
// Valid/ready channel carrying one 3D point per transfer.
// ----------------------------------------------------------------------------
interface ptr_in_if import ptr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

/* src/ptr_out_if.sv */
// ----------------------------------------------------------------------------
// Rotated point output channel
// Valid/ready channel carrying one rotated point and its status per transfer.
// ----------------------------------------------------------------------------
interface ptr_out_if import ptr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t rotated_x;
  coord_t rotated_y;
  coord_t rotated_z;
  logic   bad_normal;

  modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
                  output bad_normal, input ready);
  modport sink   (input valid, input rotated_x, input rotated_y, input rotated_z,
                  input bad_normal, output ready);
endinterface

/* src/plane_tilt_point_rotator_unit.sv */
// ----------------------------------------------------------------------------
// Plane tilt point rotator
// Rotates 3D Q16.16 points by a matrix built from a configured plane normal.
//
//   Channel  Dir  Payload                                   Handshake
//   pt_i     in   point_x, point_y, point_z                 valid/ready
//   rot_o    out  rotated_x, rotated_y, rotated_z, bad_normal valid/ready
//   cfg      in   cfg_idx_i, cfg_wdata_i                    cfg_we_i
//
// A point is registered at the input, after the nine multipliers, after the
// adders and after the saturator on its way out; one point can enter every
// cycle while no stage is stalled and setup is done. After reset and after
// any normal write the setup sequencer reruns its shared square root and
// divider loops, and no point is taken until it finishes. Each stage
// holds its item while the next one is full, so a stall loses nothing.
// ----------------------------------------------------------------------------
`include "plane_tilt_point_rotator_unit_defines.svh"

module plane_tilt_point_rotator_unit import ptr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  ptr_in_if.sink                pt_i,
  ptr_out_if.source             rot_o
);

  coord_t        nx_q, ny_q, nz_q;
  logic [1:0]    mode_q;
  logic          norm_we;
  coeff_mat_t    coeff;
  ptr_setup_st_t st;

  logic          v1_q, v2_q, v3_q, v4_q;
  logic          en1, en2, en3, en4, accept;
  coord_t        p1_q [3];
  coord_t        p2_q [3];
  coord_t        p3_q [3];
  logic          pass1_q, pass2_q, pass3_q;
  logic          inv1_q;
  logic          bad1_q, bad2_q, bad3_q, bad4_q;
  logic signed [PROD_W-1:0] prod2_q [9];
  logic signed [PROD_W-1:0] prod2_d [9];
  logic signed [SUM_W-1:0]  sum3_q [3];
  logic signed [SUM_W-1:0]  sum3_d [3];
  coord_t        r4_q [3];

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7fff_ffff);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  function automatic coord_t sat_round(logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] sh;
    sh = s >>> COEFF_FRAC_BITS;
    if (sh > SAT_HI) begin
      return coord_t'(SAT_HI[COORD_W-1:0]);
    end else if (sh < SAT_LO) begin
      return coord_t'(SAT_LO[COORD_W-1:0]);
    end
    return coord_t'(sh[COORD_W-1:0]);
  endfunction

  assign norm_we = cfg_we_i && (cfg_idx_i != REG_ROTATE_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q   <= '0;
      ny_q   <= '0;
      nz_q   <= NORMAL_Z_RESET;
      mode_q <= MODE_IDENTITY;
    end else if (cfg_we_i) begin
      unique case (ptr_reg_e'(cfg_idx_i))
        REG_NORMAL_X:    nx_q   <= coord_t'(cfg_wdata_i);
        REG_NORMAL_Y:    ny_q   <= coord_t'(cfg_wdata_i);
        REG_NORMAL_Z:    nz_q   <= coord_t'(cfg_wdata_i);
        REG_ROTATE_MODE: mode_q <= cfg_wdata_i[1:0];
        default: begin
        end
      endcase
    end
  end

  ptr_setup u_setup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .norm_x_i  (nx_q),
    .norm_y_i  (ny_q),
    .norm_z_i  (nz_q),
    .restart_i (norm_we),
    .coeff_o   (coeff),
    .status_o  (st)
  );

  assign en4        = !v4_q || rot_o.ready;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign pt_i.ready = en1 && st.ready;
  assign accept     = pt_i.valid && pt_i.ready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod2_d[3*i+j] = p1_q[i] * (inv1_q ? $signed(coeff[3*j+i]) : $signed(coeff[3*i+j]));
      end
    end
    for (int j = 0; j < 3; j++) begin
      sum3_d[j] = SUM_W'(prod2_q[j]) + SUM_W'(prod2_q[3+j]) + SUM_W'(prod2_q[6+j])
                + RND_HALF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= accept;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && accept) begin
      p1_q[0] <= pt_i.point_x;
      p1_q[1] <= pt_i.point_y;
      p1_q[2] <= pt_i.point_z;
      pass1_q <= st.bad || !(mode_q == MODE_FORWARD || mode_q == MODE_INVERSE);
      inv1_q  <= (mode_q == MODE_INVERSE);
      bad1_q  <= st.bad;
    end
    if (en2 && v1_q) begin
      prod2_q <= prod2_d;
      p2_q    <= p1_q;
      pass2_q <= pass1_q;
      bad2_q  <= bad1_q;
    end
    if (en3 && v2_q) begin
      sum3_q  <= sum3_d;
      p3_q    <= p2_q;
      pass3_q <= pass2_q;
      bad3_q  <= bad2_q;
    end
    if (en4 && v3_q) begin
      for (int j = 0; j < 3; j++) begin
        r4_q[j] <= pass3_q ? p3_q[j] : sat_round(sum3_q[j]);
      end
      bad4_q <= bad3_q;
    end
  end

  assign rot_o.valid      = v4_q;
  assign rot_o.rotated_x  = r4_q[0];
  assign rot_o.rotated_y  = r4_q[1];
  assign rot_o.rotated_z  = r4_q[2];
  assign rot_o.bad_normal = bad4_q;

  `PTR_ASSERT(a_norm_write_drops_ready, clk_i, rst_ni, norm_we |=> !st.ready)
  `PTR_ASSERT(a_ready_rise_after_quiet, clk_i, rst_ni, $rose(st.ready) |-> !$past(norm_we))
  `PTR_ASSERT_NEVER(a_no_transfer_in_setup, clk_i, rst_ni, !st.ready && pt_i.ready)

endmodule

/* src/ptr_setup.sv */
// ----------------------------------------------------------------------------
// Rotation matrix setup sequencer
// Builds the 3x3 rotation from the plane normal with one shared multiplier,
// a bit-per-cycle square root loop and a bit-per-cycle divider.
// ----------------------------------------------------------------------------
module ptr_setup import ptr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  coord_t        norm_x_i,
  input  coord_t        norm_y_i,
  input  coord_t        norm_z_i,
  input  logic          restart_i,
  output coeff_mat_t    coeff_o,
  output ptr_setup_st_t status_o
);

  localparam int MUL_W    = COORD_W + 1;
  localparam int MPROD_W  = 2 * MUL_W;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int SQRT_N   = (SQRT_ITERATIONS > COORD_W) ? COORD_W : SQRT_ITERATIONS;
  localparam int SQRT_LOW = COORD_W - SQRT_N;
  localparam int QUO_W    = COEFF_FRAC_BITS + 1;
  localparam int CNT_MAX  = (QUO_W > SQRT_N) ? QUO_W : SQRT_N;
  localparam int CNT_W    = $clog2(CNT_MAX + 1);
  localparam logic [SQ_W-1:0] ONE_INIT = SQ_W'(1) << (SQ_W - 2);
  localparam logic signed [MPROD_W-1:0] MHALF = MPROD_W'(1) << (COEFF_FRAC_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_SQUARE, ST_ROOT, ST_DIVIDE, ST_CROSS, ST_COMMIT
  } state_e;

  typedef logic signed [MUL_W-1:0] mval_t;

  state_e                      state_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        cross_q;
  logic [1:0]                  root_idx_q;
  logic [2:0]                  div_idx_q;
  logic signed [MPROD_W-1:0]   prod_q;
  logic [SQ_W-1:0]             acc_q, s_full_q, rem_q, t_q, one_q;
  logic [COORD_W-1:0]          l1_q, l2_q, l3_q, r_q;
  logic [QUO_W-1:0]            q_q;
  logic                        big_q;
  mval_t                       cx_q, cy_q, cz_q;
  coeff_mat_t                  m_q, coeff_q;
  logic                        ready_q, bad_q;

  mval_t                       mul_a, mul_b, sq_v, num;
  logic [COORD_W-1:0]          len, mag;
  mval_t                       num_abs;
  logic                        num_neg, big_d, bit_in, ge;
  logic [COORD_W:0]            r_sh;
  logic [COORD_W-1:0]          r_n;
  logic [QUO_W-1:0]            q_n;
  coeff_t                      q_ext, cval, coeff_res;
  logic [3:0]                  dest;
  logic [SQ_W:0]               t_plus;
  logic                        take;
  logic [SQ_W-1:0]             rem_n, t_n, one_n;
  logic [COORD_W-1:0]          root_now;
  logic signed [MPROD_W-1:0]   rs_full;
  mval_t                       rs;
  logic [SQ_W-1:0]             sum_n;

  function automatic mval_t ext_c(coeff_t c);
    return mval_t'(c);
  endfunction

  function automatic mval_t ext_n(coord_t c);
    return mval_t'(c);
  endfunction

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    sq_v = cross_q ? cx_q : ext_n(norm_x_i);
      2'd1:    sq_v = cross_q ? cz_q : ext_n(norm_z_i);
      default: sq_v = cross_q ? cy_q : ext_n(norm_y_i);
    endcase
    if (state_q == ST_SQUARE) begin
      mul_a = sq_v;
      mul_b = sq_v;
    end else begin
      case (cnt_q[1:0])
        2'd0:    begin mul_a = ext_c(m_q[7]); mul_b = ext_c(m_q[2]); end
        2'd1:    begin mul_a = ext_c(m_q[8]); mul_b = ext_c(m_q[0]); end
        2'd2:    begin mul_a = ext_c(m_q[6]); mul_b = ext_c(m_q[2]); end
        default: begin mul_a = ext_c(m_q[7]); mul_b = ext_c(m_q[0]); end
      endcase
    end
  end

  always_comb begin
    rs_full = (prod_q + MHALF) >>> COEFF_FRAC_BITS;
    rs      = rs_full[MUL_W-1:0];
    sum_n   = acc_q + prod_q[SQ_W-1:0];
  end

  always_comb begin
    t_plus   = {1'b0, t_q} + {1'b0, one_q};
    take     = t_plus <= {1'b0, rem_q};
    rem_n    = take ? rem_q - t_plus[SQ_W-1:0] : rem_q;
    t_n      = take ? (t_q >> 1) + one_q : (t_q >> 1);
    one_n    = one_q >> 2;
    root_now = t_n[SQRT_LOW +: COORD_W];
  end

  always_comb begin
    case (div_idx_q)
      3'd0:    begin num = ext_n(norm_x_i); len = l1_q; dest = 4'd6; end
      3'd1:    begin num = ext_n(norm_y_i); len = l1_q; dest = 4'd7; end
      3'd2:    begin num = ext_n(norm_z_i); len = l1_q; dest = 4'd8; end
      3'd3:    begin
        num  = norm_z_i[COORD_W-1] ? -ext_n(norm_z_i) : ext_n(norm_z_i);
        len  = l2_q;
        dest = 4'd0;
      end
      3'd4:    begin
        num  = norm_z_i[COORD_W-1] ? ext_n(norm_x_i) : -ext_n(norm_x_i);
        len  = l2_q;
        dest = 4'd2;
      end
      3'd5:    begin num = cx_q; len = l3_q; dest = 4'd3; end
      3'd6:    begin num = cy_q; len = l3_q; dest = 4'd4; end
      default: begin num = cz_q; len = l3_q; dest = 4'd5; end
    endcase
    num_neg   = num[MUL_W-1];
    num_abs   = num_neg ? -num : num;
    mag       = num_abs[COORD_W-1:0];
    big_d     = {1'b0, mag} >= {len, 1'b0};
    bit_in    = (cnt_q == CNT_W'(1)) ? mag[0] : 1'b0;
    r_sh      = {r_q, bit_in};
    ge        = r_sh >= {1'b0, len};
    r_n       = ge ? COORD_W'(r_sh - {1'b0, len}) : r_sh[COORD_W-1:0];
    q_n       = {q_q[QUO_W-2:0], ge};
    q_ext     = coeff_t'({1'b0, q_n});
    cval      = (big_q || q_ext > COEFF_ONE) ? COEFF_ONE : q_ext;
    coeff_res = num_neg ? -cval : cval;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_START;
      cnt_q      <= '0;
      cross_q    <= 1'b0;
      root_idx_q <= '0;
      div_idx_q  <= '0;
      prod_q     <= '0;
      acc_q      <= '0;
      s_full_q   <= '0;
      rem_q      <= '0;
      t_q        <= '0;
      one_q      <= '0;
      l1_q       <= '0;
      l2_q       <= '0;
      l3_q       <= '0;
      r_q        <= '0;
      q_q        <= '0;
      big_q      <= 1'b0;
      cx_q       <= '0;
      cy_q       <= '0;
      cz_q       <= '0;
      m_q        <= COEFF_IDENTITY;
      coeff_q    <= COEFF_IDENTITY;
      ready_q    <= 1'b0;
      bad_q      <= 1'b0;
    end else begin
      prod_q <= mul_a * mul_b;
      if (restart_i) begin
        state_q <= ST_START;
        ready_q <= 1'b0;
      end else begin
        unique case (state_q)
          ST_IDLE: begin
          end
          ST_START: begin
            cnt_q      <= '0;
            cross_q    <= 1'b0;
            if (norm_z_i == '0) begin
              coeff_q <= COEFF_IDENTITY;
              bad_q   <= 1'b1;
              ready_q <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_SQUARE;
            end
          end
          ST_SQUARE: begin
            if (cnt_q == CNT_W'(3)) begin
              s_full_q   <= sum_n;
              rem_q      <= cross_q ? sum_n : acc_q;
              t_q        <= '0;
              one_q      <= ONE_INIT;
              cnt_q      <= '0;
              root_idx_q <= cross_q ? 2'd2 : 2'd0;
              state_q    <= ST_ROOT;
            end else begin
              cnt_q <= cnt_q + CNT_W'(1);
              if (cnt_q == CNT_W'(1)) begin
                acc_q <= prod_q[SQ_W-1:0];
              end else if (cnt_q == CNT_W'(2)) begin
                acc_q <= sum_n;
              end
            end
          end
          ST_ROOT: begin
            if (cnt_q == CNT_W'(SQRT_N - 1)) begin
              cnt_q <= '0;
              case (root_idx_q)
                2'd0: begin
                  l2_q       <= root_now;
                  rem_q      <= s_full_q;
                  t_q        <= '0;
                  one_q      <= ONE_INIT;
                  root_idx_q <= 2'd1;
                end
                2'd1: begin
                  l1_q <= root_now;
                  if (root_now == '0 || l2_q == '0) begin
                    coeff_q <= COEFF_IDENTITY;
                    bad_q   <= 1'b1;
                    ready_q <= 1'b1;
                    state_q <= ST_IDLE;
                  end else begin
                    div_idx_q <= 3'd0;
                    state_q   <= ST_DIVIDE;
                  end
                end
                default: begin
                  l3_q <= root_now;
                  if (root_now == '0) begin
                    coeff_q <= COEFF_IDENTITY;
                    bad_q   <= 1'b1;
                    ready_q <= 1'b1;
                    state_q <= ST_IDLE;
                  end else begin
                    div_idx_q <= 3'd5;
                    state_q   <= ST_DIVIDE;
                  end
                end
              endcase
            end else begin
              rem_q <= rem_n;
              t_q   <= t_n;
              one_q <= one_n;
              cnt_q <= cnt_q + CNT_W'(1);
            end
          end
          ST_DIVIDE: begin
            if (cnt_q == '0) begin
              r_q   <= {1'b0, mag[COORD_W-1:1]};
              q_q   <= '0;
              big_q <= big_d;
              cnt_q <= cnt_q + CNT_W'(1);
            end else begin
              r_q <= r_n;
              q_q <= q_n;
              if (cnt_q == CNT_W'(QUO_W)) begin
                m_q[dest] <= coeff_res;
                cnt_q     <= '0;
                if (div_idx_q == 3'd4) begin
                  state_q <= ST_CROSS;
                end else if (div_idx_q == 3'd7) begin
                  state_q <= ST_COMMIT;
                end else begin
                  div_idx_q <= div_idx_q + 3'd1;
                end
              end else begin
                cnt_q <= cnt_q + CNT_W'(1);
              end
            end
          end
          ST_CROSS: begin
            cnt_q <= (cnt_q[2:0] == 3'd4) ? '0 : cnt_q + CNT_W'(1);
            case (cnt_q[2:0])
              3'd1: cx_q <= rs;
              3'd2: cy_q <= rs;
              3'd3: cy_q <= cy_q - rs;
              3'd4: begin
                cz_q    <= -rs;
                cross_q <= 1'b1;
                state_q <= ST_SQUARE;
              end
              default: begin
              end
            endcase
          end
          ST_COMMIT: begin
            coeff_q <= m_q;
            bad_q   <= 1'b0;
            ready_q <= 1'b1;
            state_q <= ST_IDLE;
          end
          default: state_q <= ST_START;
        endcase
      end
    end
  end

  assign coeff_o         = coeff_q;
  assign status_o.ready  = ready_q;
  assign status_o.bad    = bad_q;

endmodule
